// ----- rtl/gdc_pkg.sv -----
// Shared types and constants of the group dispatch cursor.
`timescale 1ns / 1ps

package gdc_pkg;

   localparam int TC_W      = 16;  // target indices, counts and group sizes
   localparam int PAYLOAD_W = 33;  // sum of the two 32-bit byte counts
   localparam int WIDTH_W   = 34;  // automatic group width, quotient plus one
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;

   localparam logic [2:0] REG_TARGET_COUNT   = 3'd0;
   localparam logic [2:0] REG_START_POSITION = 3'd1;
   localparam logic [2:0] REG_MAX_GROUPS     = 3'd2;
   localparam logic [2:0] REG_INLINE_BYTES   = 3'd3;
   localparam logic [2:0] REG_TARGET_INFO    = 3'd4;

   typedef enum logic [1:0] {
      DIV_AUTO = 2'd0,
      DIV_INIT = 2'd1,
      DIV_STEP = 2'd2
   } div_sel_type;

   typedef struct packed {
      logic [TC_W-1:0]   target_count;
      logic [TC_W-1:0]   start_position;
      logic [TC_W-1:0]   max_groups;
      logic [DATA_W-1:0] inline_bytes;
      logic [DATA_W-1:0] target_info_bytes;
   } cfg_type;

   typedef struct packed {
      logic        div_start;
      div_sel_type div_sel;
      logic        load_width;
      logic        do_init;
      logic        load_step;
      logic        do_emit;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic auto_width;
      logic init_div;
      logic out_free;
      logic step_div;
   } status_type;

endpackage

// ----- rtl/group_dispatch_cursor_top.sv -----
// Top level of the group dispatch cursor: register file, controller and datapath.
//
//   channel  direction  signals                         contents
//   req      in         req_tvalid/tready/tdata[7:0]    bit 0 restart
//   rsp      out        rsp_tvalid/tready/tdata/tlast/  tdata group_start, group_size;
//                       tuser[0]                        tlast last_group; tuser exhausted
//   csr      in         APB, 5-bit address, 32-bit data five registers at 4*i
//
// A request without restart passes through ST_IDLE, ST_EMIT and ST_CHECK when the
// step is fixed, and also ST_STEP_DIV when the step is recomputed; every division is
// one pass of the shared 33-step radix-2 divider, whose done flag is registered.
// A restart adds ST_INIT, a division for the initial step when the remaining count
// exceeds the width and, with automatic width, one more division by BULK_LIMIT.
// Reset is synchronous and clears the registers and the cursor; no clearing pass.
// The result waits in its output register; a further request is taken meanwhile
// and holds before emitting its group until that register is free.
`timescale 1ns / 1ps

module group_dispatch_cursor_top #(
   parameter int BULK_LIMIT    = 16384,
   parameter int DEFAULT_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [0] restart
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [31:0]                rsp_tdata,   // [15:0] group_start, [31:16] group_size
   output logic                       rsp_tlast,
   output logic [0:0]                 rsp_tuser,   // [0] exhausted
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [gdc_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [gdc_pkg::DATA_W-1:0] csr_pwdata,
   output logic [gdc_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   import gdc_pkg::*;

   logic [TC_W-1:0]   tc_ff, start_ff, maxg_ff;
   logic [DATA_W-1:0] inl_ff, info_ff;
   logic              wr_en;
   logic [2:0]        reg_idx;
   cfg_type           cfg;
   cmd_type           cmd;
   status_type        status;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff    <= '0;
         start_ff <= '0;
         maxg_ff  <= '0;
         inl_ff   <= '0;
         info_ff  <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_TARGET_COUNT:   tc_ff    <= csr_pwdata[TC_W-1:0];
            REG_START_POSITION: start_ff <= csr_pwdata[TC_W-1:0];
            REG_MAX_GROUPS:     maxg_ff  <= csr_pwdata[TC_W-1:0];
            REG_INLINE_BYTES:   inl_ff   <= csr_pwdata;
            REG_TARGET_INFO:    info_ff  <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_TARGET_COUNT:   csr_prdata = DATA_W'(tc_ff);
         REG_START_POSITION: csr_prdata = DATA_W'(start_ff);
         REG_MAX_GROUPS:     csr_prdata = DATA_W'(maxg_ff);
         REG_INLINE_BYTES:   csr_prdata = inl_ff;
         REG_TARGET_INFO:    csr_prdata = info_ff;
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg.target_count      = tc_ff;
   assign cfg.start_position    = start_ff;
   assign cfg.max_groups        = maxg_ff;
   assign cfg.inline_bytes      = inl_ff;
   assign cfg.target_info_bytes = info_ff;

   gdc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_restart (req_tdata[0]),
      .status      (status),
      .cmd         (cmd)
   );

   gdc_datapath #(
      .BULK_LIMIT    (BULK_LIMIT),
      .DEFAULT_WIDTH (DEFAULT_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- rtl/gdc_divider.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module gdc_divider #(
   parameter int DDW = 33,
   parameter int DVW = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [DDW-1:0] dividend,
   input  logic [DVW-1:0] divisor,
   output logic           busy,
   output logic           done,
   output logic [DDW-1:0] quotient,
   output logic [DVW-1:0] remainder
);

   localparam int CW = $clog2(DDW + 1);

   logic [DDW-1:0] quo_ff, quo_in;
   logic [DVW-1:0] rem_ff, rem_in;
   logic [DVW-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [DVW:0]   shifted;
   logic [DVW:0]   diff;

   assign shifted = {rem_ff, quo_ff[DDW-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CW'(DDW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so the low bits suffice.
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = diff[DVW-1:0];
            quo_in = {quo_ff[DDW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DVW-1:0];
            quo_in = {quo_ff[DDW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/gdc_datapath.sv -----
// Cursor registers, group arithmetic, shared divider and result register.
`timescale 1ns / 1ps

module gdc_datapath #(
   parameter int BULK_LIMIT    = 16384,
   parameter int DEFAULT_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gdc_pkg::cfg_type     cfg,
   input  gdc_pkg::cmd_type     cmd,
   output gdc_pkg::status_type  status,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,
   output logic                 rsp_tlast,
   output logic [0:0]           rsp_tuser
);

   import gdc_pkg::*;

   localparam int BL_W = $clog2(BULK_LIMIT + 1);
   localparam int DVW  = (BL_W > TC_W) ? BL_W : TC_W;

   logic [TC_W-1:0]    pos_ff, pos_in;
   logic [TC_W-1:0]    step_ff, step_in;
   logic [TC_W-1:0]    pend_ff, pend_in;
   logic               fixed_ff, fixed_in;
   logic               step_div_ff, step_div_in;
   logic [WIDTH_W-1:0] width_ff, width_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [TC_W-1:0]    rsp_start_ff, rsp_start_in;
   logic [TC_W-1:0]    rsp_size_ff, rsp_size_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_exh_ff, rsp_exh_in;

   logic [PAYLOAD_W-1:0] payload;
   logic [TC_W-1:0]      remaining_init;
   logic                 empty_range;
   logic                 init_div;
   logic [TC_W-1:0]      left;
   logic [TC_W-1:0]      size;
   logic                 exhausted;
   logic                 last;
   logic [WIDTH_W-1:0]   auto_width;
   logic                 out_free;

   logic                 div_busy;
   logic                 div_done;
   logic [PAYLOAD_W-1:0] div_dividend;
   logic [DVW-1:0]       div_divisor;
   logic [PAYLOAD_W-1:0] div_quo;
   logic [DVW-1:0]       div_rem;

   assign payload        = {1'b0, cfg.inline_bytes} + {1'b0, cfg.target_info_bytes};
   assign remaining_init = cfg.target_count - cfg.start_position;
   assign empty_range    = cfg.target_count <= cfg.start_position;
   assign init_div       = !empty_range && (WIDTH_W'(remaining_init) > width_ff);

   assign left      = cfg.target_count - pos_ff;
   assign size      = (step_ff > left) ? left : step_ff;
   assign exhausted = (pend_ff == '0) || (cfg.target_count <= pos_ff);
   assign last      = (pend_ff == TC_W'(1)) || (size == left);

   assign auto_width = WIDTH_W'(div_quo) + WIDTH_W'(1);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      case (cmd.div_sel)
         DIV_AUTO: begin
            div_dividend = payload;
            div_divisor  = DVW'(BULK_LIMIT);
         end
         DIV_INIT: begin
            div_dividend = PAYLOAD_W'(remaining_init);
            div_divisor  = DVW'(width_ff[TC_W-1:0]);
         end
         DIV_STEP: begin
            // Position has already advanced past the group just sent.
            div_dividend = PAYLOAD_W'(cfg.target_count - pos_ff);
            div_divisor  = DVW'(pend_ff);
         end
         default: begin
            div_dividend = '0;
            div_divisor  = '0;
         end
      endcase
   end

   gdc_divider #(
      .DDW (PAYLOAD_W),
      .DVW (DVW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      pos_in       = pos_ff;
      step_in      = step_ff;
      pend_in      = pend_ff;
      fixed_in     = fixed_ff;
      step_div_in  = step_div_ff;
      width_in     = width_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_start_in = rsp_start_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_exh_in   = rsp_exh_ff;

      if (cmd.load_width) begin
         if (cfg.max_groups == '0) begin
            width_in = (auto_width < WIDTH_W'(DEFAULT_WIDTH)) ? WIDTH_W'(DEFAULT_WIDTH)
                                                              : auto_width;
         end else begin
            width_in = WIDTH_W'(cfg.max_groups);
         end
      end

      if (cmd.do_init) begin
         pos_in = cfg.start_position;
         if (empty_range) begin
            pend_in  = '0;
            step_in  = '0;
            fixed_in = 1'b0;
         end else if (init_div) begin
            // Width is below the remaining count here, so it fits 16 bits.
            pend_in = width_ff[TC_W-1:0];
         end else begin
            pend_in  = remaining_init;
            step_in  = TC_W'(1);
            fixed_in = 1'b1;
         end
      end

      if (cmd.load_step) begin
         step_in  = div_quo[TC_W-1:0] + TC_W'(div_rem != '0);
         fixed_in = div_rem == '0;
      end

      if (cmd.do_emit) begin
         rsp_valid_in = 1'b1;
         if (exhausted) begin
            pend_in      = '0;
            step_div_in  = 1'b0;
            rsp_start_in = '0;
            rsp_size_in  = '0;
            rsp_last_in  = 1'b0;
            rsp_exh_in   = 1'b1;
         end else begin
            pos_in       = pos_ff + size;
            pend_in      = last ? '0 : pend_ff - TC_W'(1);
            step_div_in  = !last && !fixed_ff;
            rsp_start_in = pos_ff;
            rsp_size_in  = size;
            rsp_last_in  = last;
            rsp_exh_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_start_ff <= rsp_start_in;
      rsp_size_ff  <= rsp_size_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_exh_ff   <= rsp_exh_in;
      if (reset) begin
         pos_ff       <= '0;
         step_ff      <= '0;
         pend_ff      <= '0;
         fixed_ff     <= 1'b0;
         step_div_ff  <= 1'b0;
         width_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         step_ff      <= step_in;
         pend_ff      <= pend_in;
         fixed_ff     <= fixed_in;
         step_div_ff  <= step_div_in;
         width_ff     <= width_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.div_done   = div_done;
   assign status.auto_width = cfg.max_groups == '0;
   assign status.init_div   = init_div;
   assign status.out_free   = out_free;
   assign status.step_div   = step_div_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_size_ff, rsp_start_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_exh_ff;

   a_emit_needs_room : assert property (@(posedge clock) disable iff (reset)
      cmd.do_emit |-> out_free)
      else $error("group emitted while the result register was occupied");

   a_start_not_busy : assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider restarted while busy");

   a_step_after_div : assert property (@(posedge clock) disable iff (reset)
      cmd.load_step |-> div_done)
      else $error("step loaded without a finished division");

   a_group_not_empty : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_exh_ff |-> rsp_size_ff != '0)
      else $error("non-exhausted result carries an empty group");

   a_exhausted_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_exh_ff |-> rsp_size_ff == '0 && rsp_start_ff == '0 && !rsp_last_ff)
      else $error("exhausted result carries group fields");

endmodule

// ----- rtl/gdc_ctrl.sv -----
// Sequencing state machine of the group dispatch cursor.
`timescale 1ns / 1ps

module gdc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_restart,
   input  gdc_pkg::status_type status,
   output gdc_pkg::cmd_type    cmd
);

   import gdc_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_AUTO_DIV = 7'b0000010,
      ST_INIT     = 7'b0000100,
      ST_INIT_DIV = 7'b0001000,
      ST_EMIT     = 7'b0010000,
      ST_CHECK    = 7'b0100000,
      ST_STEP_DIV = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (!req_restart) begin
                  state_in = ST_EMIT;
               end else if (status.auto_width) begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = DIV_AUTO;
                  state_in      = ST_AUTO_DIV;
               end else begin
                  cmd.load_width = 1'b1;
                  state_in       = ST_INIT;
               end
            end
         end
         ST_AUTO_DIV: begin
            if (status.div_done) begin
               cmd.load_width = 1'b1;
               state_in       = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.do_init = 1'b1;
            if (status.init_div) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_INIT;
               state_in      = ST_INIT_DIV;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_INIT_DIV: begin
            if (status.div_done) begin
               cmd.load_step = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.do_emit = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.step_div) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_STEP;
               state_in      = ST_STEP_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_STEP_DIV: begin
            if (status.div_done) begin
               cmd.load_step = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench of the group dispatch cursor, driven through its request and APB ports.
`timescale 1ns / 1ps

module tb;
   import gdc_pkg::*;

   localparam int BULK_LIMIT    = 16384;
   localparam int DEFAULT_WIDTH = 16;
   localparam int CYCLE_LIMIT   = 1500000;
   localparam int RANDOM_ITEMS  = 700;
   localparam int QUIET_ITEMS   = 100;
   localparam int STEP_CYCLES   = 80;
   localparam int TAIL_CYCLES   = 150;

   typedef struct {
      logic [15:0] start;
      logic [15:0] size;
      logic        last;
      logic        exhausted;
   } group_type;

   class dispatch_scoreboard;
      bit [15:0]   target_count;
      bit [15:0]   start_position;
      bit [15:0]   max_groups;
      bit [31:0]   inline_bytes;
      bit [31:0]   target_info_bytes;
      int unsigned position;
      int unsigned step;
      int unsigned groups_left;
      bit          step_fixed;
      group_type   expected_groups[$];
      int          errors;
      int          requests;

      function void load_register(logic [2:0] idx, logic [31:0] value);
         case (idx)
            REG_TARGET_COUNT:   target_count      = value[15:0];
            REG_START_POSITION: start_position    = value[15:0];
            REG_MAX_GROUPS:     max_groups        = value[15:0];
            REG_INLINE_BYTES:   inline_bytes      = value;
            REG_TARGET_INFO:    target_info_bytes = value;
            default: ;
         endcase
      endfunction

      function void restart_cursor();
         longint unsigned width;
         longint unsigned payload;
         int unsigned     remaining;
         width = 64'(max_groups);
         if (width == 0) begin
            // The byte counts are summed at 64 bits, so the sum never wraps.
            payload = 64'(inline_bytes);
            payload += 64'(target_info_bytes);
            width = payload / BULK_LIMIT + 1;
            if (width < DEFAULT_WIDTH)
               width = 64'(DEFAULT_WIDTH);
         end
         position = 32'(start_position);
         if (target_count <= start_position) begin
            groups_left = 0;
            step        = 0;
            step_fixed  = 1'b0;
            return;
         end
         remaining = 32'(target_count) - 32'(start_position);
         if (remaining > width) begin
            groups_left = 32'(width);
            step        = remaining / groups_left;
            if (remaining % groups_left != 0) begin
               step++;
               step_fixed = 1'b0;
            end else begin
               step_fixed = 1'b1;
            end
         end else begin
            groups_left = remaining;
            step        = 1;
            step_fixed  = 1'b1;
         end
      endfunction

      function void note_request(bit restart);
         group_type   g;
         int unsigned left;
         int unsigned rest;
         requests++;
         if (restart)
            restart_cursor();
         g = '{default: '0};
         if (groups_left == 0 || target_count <= position) begin
            groups_left = 0;
            g.exhausted = 1'b1;
         end else begin
            left    = target_count - position;
            g.start = position[15:0];
            g.size  = (step > left) ? left[15:0] : step[15:0];
            g.last  = (groups_left == 1) || (g.size == left);
            position = (position + g.size) & 32'hFFFF;
            if (g.last) begin
               groups_left = 0;
            end else begin
               groups_left--;
               if (!step_fixed) begin
                  rest = target_count - position;
                  step = rest / groups_left;
                  if (rest % groups_left != 0)
                     step++;
                  else
                     step_fixed = 1'b1;
                  step &= 32'hFFFF;
               end
            end
         end
         expected_groups.push_back(g);
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_result(group_type got);
         group_type want;
         if (expected_groups.size() == 0) begin
            $display("%0t: unexpected result, actual start %0h size %0h last %0b exhausted %0b",
                     $time, got.start, got.size, got.last, got.exhausted);
            errors++;
            return;
         end
         want = expected_groups.pop_front();
         compare_field("group_start", want.start, got.start);
         compare_field("group_size", want.size, got.size);
         compare_field("last_group", 16'(want.last), 16'(got.last));
         compare_field("exhausted", 16'(want.exhausted), 16'(got.exhausted));
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [7:0]          req_tdata;   // [0] restart
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [31:0]         rsp_tdata;   // [15:0] group_start, [31:16] group_size
   logic                rsp_tlast;
   logic [0:0]          rsp_tuser;   // [0] exhausted
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [ADDR_W-1:0]   csr_paddr;
   logic [DATA_W-1:0]   csr_pwdata;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   dispatch_scoreboard sb = new;
   bit                 idling = 1'b1;
   int                 cycles;
   group_type          observed;

   group_dispatch_cursor_top #(
      .BULK_LIMIT    (BULK_LIMIT),
      .DEFAULT_WIDTH (DEFAULT_WIDTH)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         observed.start     = rsp_tdata[15:0];
         observed.size      = rsp_tdata[31:16];
         observed.last      = rsp_tlast;
         observed.exhausted = rsp_tuser[0];
         sb.check_result(observed);
      end
   end

   // The result side stalls in random bursts while idling is enabled.
   initial begin
      int stall;
      stall = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (stall == 0 && idling && $urandom_range(0, 9) == 0)
            stall = $urandom_range(1, 9);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_request(bit restart);
      int gap;
      gap = (idling && $urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, restart};
      do @(posedge clock); while (!req_tready);
      sb.note_request(restart);
      @(negedge clock);
   endtask

   task automatic send_burst(bit restart_first, int count);
      for (int i = 0; i < count; i++)
         send_request(restart_first && i == 0);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.expected_groups.size() != 0) @(negedge clock);
      // The cursor may still be working out its next step after the last result has left.
      repeat (STEP_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [2:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.load_register(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(int tc, int first, int groups, logic [31:0] inl, logic [31:0] info);
      settle();
      write_register(REG_TARGET_COUNT, tc);
      write_register(REG_START_POSITION, first);
      write_register(REG_MAX_GROUPS, groups);
      write_register(REG_INLINE_BYTES, inl);
      write_register(REG_TARGET_INFO, info);
   endtask

   initial begin
      int rand_base;
      int span;
      int first;
      int tc;
      int groups;
      int mode;
      int n;
      int half;
      int cut;
      bit all_regs;
      logic [31:0] inl;
      logic [31:0] info;

      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // No restart since reset, then an empty range from the cleared registers.
      send_request(1'b0);
      send_request(1'b1);
      // Uneven split whose step is recomputed, then a request past the final group.
      configure(10, 0, 3, 0, 0);
      send_burst(1'b1, 4);
      // Automatic width with no payload falls back to the default width.
      configure(7, 2, 0, 0, 0);
      send_burst(1'b1, 5);
      configure(65535, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_burst(1'b1, 2);
      // Largest payload: the sum must not wrap.
      configure(65535, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_burst(1'b1, 2);
      configure(100, 0, 0, 20 * BULK_LIMIT, 5);
      send_burst(1'b1, 2);
      configure(65535, 65535, 65535, 0, 0);
      send_burst(1'b1, 1);
      configure(40, 50, 2, 0, 0);
      send_burst(1'b1, 1);
      // The range shrinks mid-run: first the group is cut short, then nothing is left.
      configure(100, 0, 4, 0, 0);
      send_burst(1'b1, 1);
      settle();
      write_register(REG_TARGET_COUNT, 30);
      send_burst(1'b0, 2);
      send_burst(1'b1, 1);
      settle();
      write_register(REG_TARGET_COUNT, 5);
      send_burst(1'b0, 1);

      rand_base = sb.requests;
      all_regs  = 1'b1;
      while (sb.requests - rand_base < RANDOM_ITEMS) begin
         settle();
         idling = (sb.requests - rand_base < RANDOM_ITEMS - QUIET_ITEMS) &&
                  ($urandom_range(0, 3) != 0);

         span  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 48);
         first = $urandom_range(0, 65535);
         case ($urandom_range(0, 5))
            0: first = 0;
            1: first = 65535 - span;
            default: ;
         endcase
         if (first < 0)
            first = 0;
         tc = (first + span > 65535) ? 65535 : first + span;
         if ($urandom_range(0, 9) == 0)
            tc = $urandom_range(0, first);
         case ($urandom_range(0, 9))
            0, 1, 2: groups = 0;
            8:       groups = $urandom_range(0, 65535);
            9:       groups = 65535;
            default: groups = $urandom_range(1, 12);
         endcase
         case ($urandom_range(0, 3))
            0: begin
               inl  = 0;
               info = 0;
            end
            1: begin
               inl  = $urandom_range(0, 40 * BULK_LIMIT);
               info = $urandom_range(0, 40 * BULK_LIMIT);
            end
            2: begin
               inl  = $urandom;
               info = $urandom;
            end
            default: begin
               inl  = 32'hFFFF_FFFF;
               info = $urandom;
            end
         endcase
         if (all_regs || $urandom_range(0, 2) != 0) write_register(REG_TARGET_COUNT, tc);
         if (all_regs || $urandom_range(0, 2) != 0) write_register(REG_START_POSITION, first);
         if (all_regs || $urandom_range(0, 2) != 0) write_register(REG_MAX_GROUPS, groups);
         if (all_regs || $urandom_range(0, 2) != 0) write_register(REG_INLINE_BYTES, inl);
         if (all_regs || $urandom_range(0, 2) != 0) write_register(REG_TARGET_INFO, info);
         all_regs = 1'b0;

         // Mostly a complete walk through the groups; some runs are broken off,
         // carry stray restarts, or see the range end moved part way.
         mode = $urandom_range(0, 9);
         send_request(1'b1);
         n = sb.groups_left;
         if (n > 40)
            n = $urandom_range(1, 40);
         else
            n += $urandom_range(0, 2);
         if (mode == 0)
            n = $urandom_range(0, n);
         half = (mode == 2) ? n / 2 : n;
         repeat (half) send_request((mode == 1) ? 1'($urandom_range(0, 1)) : 1'b0);
         if (mode == 2) begin
            settle();
            cut = int'(sb.position) + $urandom_range(0, 24) - 4;
            if (cut < 0)
               cut = 0;
            if (cut > 65535)
               cut = 65535;
            write_register(REG_TARGET_COUNT, cut);
            repeat (n - half + 2) send_request(1'b0);
         end
      end

      req_tvalid <= 1'b0;
      while (sb.expected_groups.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.expected_groups.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/gdc_pkg.sv
rtl/gdc_divider.sv
rtl/gdc_datapath.sv
rtl/gdc_ctrl.sv
rtl/group_dispatch_cursor_top.sv
dv/tb.sv
